@@ hw/rtl/touch_affine_calibrate_hysteresis_unit_macros.svh @@
// Assertion macros for the touch calibration unit.
`ifndef TOUCH_AFFINE_CALIBRATE_HYSTERESIS_UNIT_MACROS_SVH
`define TOUCH_AFFINE_CALIBRATE_HYSTERESIS_UNIT_MACROS_SVH
`ifndef SYNTH
`define TACH_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tach: same-cycle check failed");
`define TACH_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tach: next-cycle check failed");
`else
`define TACH_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define TACH_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/tach_pkg.sv @@
// Shared types and constants for the touch calibration unit.
package tach_pkg;

    localparam int PEN_W      = 16;
    localparam int COEF_W     = 32;
    localparam int PROD_W     = 2 * COEF_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int QUO_W      = 33;
    localparam int SCALE_W    = 31;
    localparam int OUT_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int NUM_AXES   = 2;
    localparam int DIV_STEPS  = QUO_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    // Hysteresis: quarter-pixel units, slop of three quarters of a pixel.
    localparam int         QUARTERS  = 4;
    localparam int         HYST_SLOP = QUARTERS * 3 / 4;
    localparam logic [1:0] FRAC_MASK = 2'h3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE,
        CFG_COEF_A,
        CFG_COEF_B,
        CFG_COEF_C,
        CFG_COEF_D,
        CFG_COEF_E,
        CFG_COEF_F,
        CFG_SCALE
    } cfg_index_t;

    typedef enum logic [1:0] {
        MUL_AX,
        MUL_BY,
        MUL_DX,
        MUL_EY
    } mul_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DRAIN,
        ST_DIV_INIT,
        ST_DIV,
        ST_SAT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic    load;
        logic    mul_en;
        mul_op_t mul_op;
        logic    div_init;
        logic    div_step;
        logic    sat;
        logic    finish;
    } dp_cmd_t;

    typedef struct packed {
        logic transform_enable;
    } dp_status_t;

endpackage

@@ hw/rtl/tach_if.sv @@
// Channel interfaces: sample input, result output, register write.
interface tach_sample_if #(parameter int RAW_WIDTH = 16) ();
    logic                           valid;
    logic                           ready;
    logic signed [tach_pkg::PEN_W-1:0] pen_word;
    logic signed [RAW_WIDTH-1:0]    raw_x;
    logic signed [RAW_WIDTH-1:0]    raw_y;

    modport source (output valid, output pen_word, output raw_x, output raw_y, input ready);
    modport sink   (input valid, input pen_word, input raw_x, input raw_y, output ready);
endinterface

interface tach_result_if ();
    logic                              valid;
    logic                              ready;
    logic signed [tach_pkg::OUT_W-1:0] screen_x;
    logic signed [tach_pkg::OUT_W-1:0] screen_y;
    logic                              pen_down;

    modport source (output valid, output screen_x, output screen_y, output pen_down,
                    input ready);
    modport sink   (input valid, input screen_x, input screen_y, input pen_down,
                    output ready);
endinterface

interface tach_cfg_if ();
    logic                               valid;
    logic                               ready;
    logic [tach_pkg::CFG_IDX_W-1:0]     index;
    logic [tach_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/touch_affine_calibrate_hysteresis_unit.sv @@
// Touch sample conditioner: affine calibration with quarter-pixel hysteresis. With the
// transform enabled a sample passes through the products a*x, b*y, d*x and e*y on the
// single shared 32x32 multiplier, a drain step that folds in the last product, divider
// setup, the restoring divider (one quotient bit per cycle, both axes in parallel),
// saturation and commit. With the transform off the sample goes straight from idle to
// commit. Commit waits while the output register holds a result that is not being taken.
// A new sample is accepted only in idle, so not before the last one is committed. The result
// sits in an output register, and the next sample is accepted in the cycle after commit even
// if that result has not been taken yet.
// Register writes are always accepted and must only be issued while the unit is idle.
`include "touch_affine_calibrate_hysteresis_unit_macros.svh"

module touch_affine_calibrate_hysteresis_unit #(
    parameter int RAW_WIDTH = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    tach_sample_if.sink    sample,
    tach_result_if.source  result,
    tach_cfg_if.sink       cfg
);

    tach_pkg::dp_cmd_t    cmd;
    tach_pkg::dp_status_t status;

    assign cfg.ready = 1'b1;

    tach_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    tach_datapath #(
        .RAW_WIDTH (RAW_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg.valid && cfg.ready),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .pen_word  (sample.pen_word),
        .raw_x     (sample.raw_x),
        .raw_y     (sample.raw_y),
        .cmd       (cmd),
        .status    (status),
        .screen_x  (result.screen_x),
        .screen_y  (result.screen_y),
        .pen_down  (result.pen_down)
    );

    `TACH_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, sample.valid && sample.ready, !sample.ready)
    `TACH_ASSERT_IMP(a_load_on_accept, clk, rst_n, cmd.load, sample.valid && sample.ready)
    `TACH_ASSERT_IMP(a_no_overwrite, clk, rst_n, cmd.finish, !result.valid || result.ready)
    `TACH_ASSERT_NEXT(a_commit_shows, clk, rst_n, cmd.finish, result.valid)

endmodule

@@ hw/rtl/tach_datapath.sv @@
// Datapath: registers, shared multiplier, dual restoring divider, hysteresis.
module tach_datapath #(
    parameter int RAW_WIDTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr,
    input  logic [tach_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tach_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic signed [tach_pkg::PEN_W-1:0]     pen_word,
    input  logic signed [RAW_WIDTH-1:0]           raw_x,
    input  logic signed [RAW_WIDTH-1:0]           raw_y,
    input  tach_pkg::dp_cmd_t                     cmd,
    output tach_pkg::dp_status_t                  status,
    output logic signed [tach_pkg::OUT_W-1:0]     screen_x,
    output logic signed [tach_pkg::OUT_W-1:0]     screen_y,
    output logic                                  pen_down
);

    localparam int COEF_W  = tach_pkg::COEF_W;
    localparam int PROD_W  = tach_pkg::PROD_W;
    localparam int SUM_W   = tach_pkg::SUM_W;
    localparam int QUO_W   = tach_pkg::QUO_W;
    localparam int SCALE_W = tach_pkg::SCALE_W;
    localparam int OUT_W   = tach_pkg::OUT_W;
    localparam int NA      = tach_pkg::NUM_AXES;

    // Configuration
    logic                      enable_reg;
    logic signed [COEF_W-1:0]  coef_a_reg, coef_b_reg, coef_c_reg;
    logic signed [COEF_W-1:0]  coef_d_reg, coef_e_reg, coef_f_reg;
    logic [SCALE_W-1:0]        scale_reg;

    // Captured sample
    logic signed [RAW_WIDTH-1:0] x_reg, y_reg;
    logic                        pen_reg;

    // Multiply / accumulate
    logic signed [COEF_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [PROD_W-1:0]  prod_reg;
    logic                      prod_dst_reg;
    logic                      prod_valid_reg;
    logic signed [SUM_W-1:0]   acc_reg [NA];

    // Divider
    logic [SCALE_W-1:0]        divisor;
    logic [SUM_W-1:0]          mag      [NA];
    logic [QUO_W-1:0]          high     [NA];
    logic                      ovf_c    [NA];
    logic [SCALE_W:0]          rem_sh   [NA];
    logic                      ge       [NA];
    logic [SCALE_W:0]          rem_sub  [NA];
    logic [SCALE_W-1:0]        rem_reg  [NA];
    logic [QUO_W-1:0]          quo_reg  [NA];
    logic                      neg_reg  [NA];
    logic                      ovf_reg  [NA];

    // Saturation and hysteresis
    logic signed [OUT_W-1:0]   fresh_c   [NA];
    logic signed [OUT_W-1:0]   fresh_reg [NA];
    logic signed [OUT_W:0]     diff      [NA];
    logic signed [OUT_W-1:0]   held_next [NA];
    logic signed [OUT_W-1:0]   held_reg  [NA];

    assign status.transform_enable = enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            coef_a_reg <= COEF_W'(1);
            coef_b_reg <= '0;
            coef_c_reg <= '0;
            coef_d_reg <= '0;
            coef_e_reg <= COEF_W'(1);
            coef_f_reg <= '0;
            scale_reg  <= SCALE_W'(1);
        end
        else if (cfg_wr)
        begin
            case (tach_pkg::cfg_index_t'(cfg_index))
                tach_pkg::CFG_ENABLE: enable_reg <= cfg_data[0];
                tach_pkg::CFG_COEF_A: coef_a_reg <= cfg_data;
                tach_pkg::CFG_COEF_B: coef_b_reg <= cfg_data;
                tach_pkg::CFG_COEF_C: coef_c_reg <= cfg_data;
                tach_pkg::CFG_COEF_D: coef_d_reg <= cfg_data;
                tach_pkg::CFG_COEF_E: coef_e_reg <= cfg_data;
                tach_pkg::CFG_COEF_F: coef_f_reg <= cfg_data;
                tach_pkg::CFG_SCALE:  scale_reg  <= cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cmd.mul_op)
            tach_pkg::MUL_AX: begin mul_a = coef_a_reg; mul_b = COEF_W'(x_reg); end
            tach_pkg::MUL_BY: begin mul_a = coef_b_reg; mul_b = COEF_W'(y_reg); end
            tach_pkg::MUL_DX: begin mul_a = coef_d_reg; mul_b = COEF_W'(x_reg); end
            tach_pkg::MUL_EY: begin mul_a = coef_e_reg; mul_b = COEF_W'(y_reg); end
            default:          begin mul_a = coef_a_reg; mul_b = COEF_W'(x_reg); end
        endcase
        prod_next = mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prod_valid_reg <= 1'b0;
        else
            prod_valid_reg <= cmd.mul_en;
    end

    // Zero scale divides as one.
    assign divisor = (scale_reg == '0) ? SCALE_W'(1) : scale_reg;

    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            mag[i]     = acc_reg[i][SUM_W-1] ? SUM_W'(-acc_reg[i]) : SUM_W'(acc_reg[i]);
            high[i]    = mag[i][SUM_W-1:SUM_W-QUO_W];
            ovf_c[i]   = high[i] >= QUO_W'(divisor);
            rem_sh[i]  = {rem_reg[i], quo_reg[i][QUO_W-1]};
            ge[i]      = rem_sh[i] >= (SCALE_W+1)'(divisor);
            rem_sub[i] = rem_sh[i] - (SCALE_W+1)'(divisor);

            // Quotient magnitude is below 2^33 unless flagged overflow.
            if (neg_reg[i])
            begin
                if (ovf_reg[i] || quo_reg[i][QUO_W-1] ||
                    (quo_reg[i][OUT_W-1] && (quo_reg[i][OUT_W-2:0] != '0)))
                    fresh_c[i] = {1'b1, {(OUT_W-1){1'b0}}};
                else
                    fresh_c[i] = OUT_W'(-quo_reg[i][OUT_W-1:0]);
            end
            else
            begin
                if (ovf_reg[i] || quo_reg[i][QUO_W-1] || quo_reg[i][OUT_W-1])
                    fresh_c[i] = {1'b0, {(OUT_W-1){1'b1}}};
                else
                    fresh_c[i] = quo_reg[i][OUT_W-1:0];
            end

            diff[i] = (OUT_W+1)'(fresh_reg[i]) - (OUT_W+1)'(held_reg[i]);
            if ((diff[i] < (OUT_W+1)'(tach_pkg::HYST_SLOP)) &&
                (diff[i] > -(OUT_W+1)'(tach_pkg::HYST_SLOP)))
                held_next[i] = held_reg[i];
            else
                held_next[i] = fresh_reg[i] & ~OUT_W'(tach_pkg::FRAC_MASK);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg      <= raw_x;
            y_reg      <= raw_y;
            pen_reg    <= (pen_word != '0);
            acc_reg[0] <= SUM_W'(coef_c_reg);
            acc_reg[1] <= SUM_W'(coef_f_reg);
        end
        else if (prod_valid_reg)
        begin
            acc_reg[prod_dst_reg] <= acc_reg[prod_dst_reg] + SUM_W'(prod_reg);
        end

        if (cmd.mul_en)
        begin
            prod_reg     <= prod_next;
            prod_dst_reg <= (cmd.mul_op == tach_pkg::MUL_DX) ||
                            (cmd.mul_op == tach_pkg::MUL_EY);
        end

        for (int i = 0; i < NA; i++)
        begin
            if (cmd.div_init)
            begin
                neg_reg[i] <= acc_reg[i][SUM_W-1];
                ovf_reg[i] <= ovf_c[i];
                rem_reg[i] <= ovf_c[i] ? '0 : high[i][SCALE_W-1:0];
                quo_reg[i] <= mag[i][QUO_W-1:0];
            end
            else if (cmd.div_step)
            begin
                rem_reg[i] <= ge[i] ? rem_sub[i][SCALE_W-1:0] : rem_sh[i][SCALE_W-1:0];
                quo_reg[i] <= {quo_reg[i][QUO_W-2:0], ge[i]};
            end
            if (cmd.sat)
                fresh_reg[i] <= fresh_c[i];
        end

        if (cmd.finish)
        begin
            pen_down <= pen_reg;
            if (enable_reg)
            begin
                screen_x <= held_next[0] >>> 2;
                screen_y <= held_next[1] >>> 2;
            end
            else
            begin
                screen_x <= OUT_W'(x_reg);
                screen_y <= OUT_W'(y_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg[0] <= '0;
            held_reg[1] <= '0;
        end
        else if (cmd.finish && enable_reg)
        begin
            held_reg[0] <= held_next[0];
            held_reg[1] <= held_next[1];
        end
    end

endmodule

@@ hw/rtl/tach_ctrl.sv @@
// Controller: sequences capture, multiply, divide and commit of one sample.
module tach_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  tach_pkg::dp_status_t status,
    output tach_pkg::dp_cmd_t    cmd
);

    localparam int CNT_W = tach_pkg::CNT_W;

    tach_pkg::state_t  state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic              slot_free;

    // Output register may be refilled in the same cycle it drains.
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            tach_pkg::ST_IDLE:
            begin
                cnt_next = '0;
                if (in_valid)
                    state_next = status.transform_enable ? tach_pkg::ST_MUL
                                                         : tach_pkg::ST_FINISH;
            end
            tach_pkg::ST_MUL:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (tach_pkg::mul_op_t'(cnt_reg[1:0]) == tach_pkg::MUL_EY)
                    state_next = tach_pkg::ST_DRAIN;
            end
            tach_pkg::ST_DRAIN:    state_next = tach_pkg::ST_DIV_INIT;
            tach_pkg::ST_DIV_INIT:
            begin
                cnt_next   = '0;
                state_next = tach_pkg::ST_DIV;
            end
            tach_pkg::ST_DIV:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(tach_pkg::DIV_STEPS - 1))
                    state_next = tach_pkg::ST_SAT;
            end
            tach_pkg::ST_SAT:      state_next = tach_pkg::ST_FINISH;
            tach_pkg::ST_FINISH:
            begin
                if (slot_free)
                    state_next = tach_pkg::ST_IDLE;
            end
            default:               state_next = tach_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.mul_op   = tach_pkg::mul_op_t'(cnt_reg[1:0]);
        case (state_reg)
            tach_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            tach_pkg::ST_MUL:      cmd.mul_en   = 1'b1;
            tach_pkg::ST_DIV_INIT: cmd.div_init = 1'b1;
            tach_pkg::ST_DIV:      cmd.div_step = 1'b1;
            tach_pkg::ST_SAT:      cmd.sat      = 1'b1;
            tach_pkg::ST_FINISH:   cmd.finish   = slot_free;
            default: ;
        endcase
    end

    always_comb
    begin
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tach_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ tb/sv/tb_touch_affine_calibrate_hysteresis_unit.sv @@
// Testbench for the touch calibration unit: directed table plus random phases, self-checking.
`timescale 1ns / 1ps

module tb_touch_affine_calibrate_hysteresis_unit;

    localparam int     RAW_W        = 16;
    localparam int     RANDOM_ITEMS = 600;
    localparam int     STALL_LIMIT  = 2000;
    localparam int     LONG_HOLD    = 300;
    localparam int     DRAIN_CYCLES = 64;
    localparam longint SAT_HI       = 64'sd2147483647;
    localparam longint SAT_LO       = -64'sd2147483648;
    // three quarter pixels
    localparam longint DEADBAND     = 3;

    typedef struct packed {
        logic signed [tach_pkg::OUT_W-1:0] sx;
        logic signed [tach_pkg::OUT_W-1:0] sy;
        logic                              pen;
    } screen_pt_t;

    typedef enum logic [1:0] {
        STEP_WRITE,
        STEP_SAMPLE,
        STEP_CHECKED
    } step_kind_t;

    typedef struct {
        step_kind_t           kind;
        tach_pkg::cfg_index_t idx;
        logic [31:0]          data;
        logic [15:0]          pen;
        logic [15:0]          x;
        logic [15:0]          y;
        logic [31:0]          ex;
        logic [31:0]          ey;
        logic                 ep;
    } step_t;

    localparam int NUM_STEPS = 35;

    logic clk;
    logic rst_n;

    tach_sample_if #(.RAW_WIDTH(RAW_W)) sample_ch ();
    tach_result_if                      result_ch ();
    tach_cfg_if                         cfg_ch ();

    touch_affine_calibrate_hysteresis_unit #(.RAW_WIDTH(RAW_W)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Calibration state mirrored by the predictor
    logic                         cal_on;
    logic signed [31:0]           ka, kb, kc, kd, ke, kf;
    logic [tach_pkg::SCALE_W-1:0] scale_q;
    logic signed [31:0]           held_x, held_y;

    screen_pt_t pending_points[$];
    int         errors;
    int         idle_cycles;
    bit         fast_send;
    bit         fast_take;
    bit         hold_output;

    step_t steps [NUM_STEPS] = '{
        // transform off after reset: raw pass-through
        '{STEP_CHECKED, tach_pkg::CFG_ENABLE, 0, 16'h0000, 16'h0000, 16'h0000, 32'h0, 32'h0, 0},
        '{STEP_CHECKED, tach_pkg::CFG_ENABLE, 0, 16'h8000, 16'h8000, 16'h7fff,
          32'hffff8000, 32'h00007fff, 1},
        '{STEP_CHECKED, tach_pkg::CFG_ENABLE, 0, 16'h0001, 16'h7fff, 16'h8000,
          32'h00007fff, 32'hffff8000, 1},
        '{STEP_CHECKED, tach_pkg::CFG_ENABLE, 0, 16'hffff, 16'h5555, 16'haaaa,
          32'h00005555, 32'hffffaaaa, 1},
        // identity transform, hysteresis move / hold / move
        '{STEP_WRITE, tach_pkg::CFG_ENABLE, 32'hffffffff, 0, 0, 0, 0, 0, 0},
        '{STEP_CHECKED, tach_pkg::CFG_ENABLE, 0, 16'h0001, 16'h0064, 16'hff9c,
          32'h00000019, 32'hffffffe7, 1},
        '{STEP_CHECKED, tach_pkg::CFG_ENABLE, 0, 16'h0001, 16'h0066, 16'hff9e,
          32'h00000019, 32'hffffffe7, 1},
        '{STEP_CHECKED, tach_pkg::CFG_ENABLE, 0, 16'h0001, 16'h006b, 16'hff99,
          32'h0000001a, 32'hffffffe6, 1},
        // extreme coefficients: saturation and full-range hysteresis distance
        '{STEP_WRITE, tach_pkg::CFG_COEF_A, 32'h7fffffff, 0, 0, 0, 0, 0, 0},
        '{STEP_WRITE, tach_pkg::CFG_COEF_B, 32'h7fffffff, 0, 0, 0, 0, 0, 0},
        '{STEP_WRITE, tach_pkg::CFG_COEF_C, 32'h7fffffff, 0, 0, 0, 0, 0, 0},
        '{STEP_WRITE, tach_pkg::CFG_COEF_D, 32'h80000000, 0, 0, 0, 0, 0, 0},
        '{STEP_WRITE, tach_pkg::CFG_COEF_E, 32'h80000000, 0, 0, 0, 0, 0, 0},
        '{STEP_WRITE, tach_pkg::CFG_COEF_F, 32'h80000000, 0, 0, 0, 0, 0, 0},
        '{STEP_CHECKED, tach_pkg::CFG_ENABLE, 0, 16'h0100, 16'h7fff, 16'h7fff,
          32'h1fffffff, 32'he0000000, 1},
        '{STEP_CHECKED, tach_pkg::CFG_ENABLE, 0, 16'h8000, 16'h8000, 16'h8000,
          32'he0000000, 32'h1fffffff, 1},
        '{STEP_CHECKED, tach_pkg::CFG_ENABLE, 0, 16'h0000, 16'h0000, 16'h0000,
          32'h1fffffff, 32'he0000000, 0},
        // zero divisor acts as one
        '{STEP_WRITE, tach_pkg::CFG_SCALE,  32'h00000000, 0, 0, 0, 0, 0, 0},
        '{STEP_WRITE, tach_pkg::CFG_COEF_A, 32'h00000003, 0, 0, 0, 0, 0, 0},
        '{STEP_WRITE, tach_pkg::CFG_COEF_B, 32'hfffffffb, 0, 0, 0, 0, 0, 0},
        '{STEP_WRITE, tach_pkg::CFG_COEF_C, 32'h00000007, 0, 0, 0, 0, 0, 0},
        '{STEP_WRITE, tach_pkg::CFG_COEF_D, 32'hffffffff, 0, 0, 0, 0, 0, 0},
        '{STEP_WRITE, tach_pkg::CFG_COEF_E, 32'h00000002, 0, 0, 0, 0, 0, 0},
        '{STEP_WRITE, tach_pkg::CFG_COEF_F, 32'hfffffff7, 0, 0, 0, 0, 0, 0},
        '{STEP_SAMPLE, tach_pkg::CFG_ENABLE, 0, 16'h0040, 16'h03e8, 16'hf830, 0, 0, 0},
        '{STEP_SAMPLE, tach_pkg::CFG_ENABLE, 0, 16'h2000, 16'hfb2e, 16'h10e1, 0, 0, 0},
        // bit 31 of the scale word is dropped; negative sums truncate toward zero
        '{STEP_WRITE, tach_pkg::CFG_SCALE,  32'h80000007, 0, 0, 0, 0, 0, 0},
        '{STEP_SAMPLE, tach_pkg::CFG_ENABLE, 0, 16'h0004, 16'hfc18, 16'h03e8, 0, 0, 0},
        '{STEP_SAMPLE, tach_pkg::CFG_ENABLE, 0, 16'h0000, 16'h03e7, 16'hfc19, 0, 0, 0},
        '{STEP_WRITE, tach_pkg::CFG_SCALE,  32'h7fffffff, 0, 0, 0, 0, 0, 0},
        '{STEP_SAMPLE, tach_pkg::CFG_ENABLE, 0, 16'h0010, 16'h7fff, 16'h8000, 0, 0, 0},
        // back to raw, then on again with the held values kept
        '{STEP_WRITE, tach_pkg::CFG_ENABLE, 32'hfffffffe, 0, 0, 0, 0, 0, 0},
        '{STEP_CHECKED, tach_pkg::CFG_ENABLE, 0, 16'h0000, 16'hffff, 16'h0001,
          32'hffffffff, 32'h00000001, 0},
        '{STEP_WRITE, tach_pkg::CFG_ENABLE, 32'h00000001, 0, 0, 0, 0, 0, 0},
        '{STEP_SAMPLE, tach_pkg::CFG_ENABLE, 0, 16'h0002, 16'h0200, 16'hfe00, 0, 0, 0}
    };

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void load_register(input tach_pkg::cfg_index_t idx,
                                          input logic [31:0] value);
        case (idx)
            tach_pkg::CFG_ENABLE: cal_on  = value[0];
            tach_pkg::CFG_COEF_A: ka      = value;
            tach_pkg::CFG_COEF_B: kb      = value;
            tach_pkg::CFG_COEF_C: kc      = value;
            tach_pkg::CFG_COEF_D: kd      = value;
            tach_pkg::CFG_COEF_E: ke      = value;
            tach_pkg::CFG_COEF_F: kf      = value;
            tach_pkg::CFG_SCALE:  scale_q = value[tach_pkg::SCALE_W-1:0];
            default: ;
        endcase
    endfunction

    // Exact weighted sum, truncating divide, 32-bit saturation
    function automatic longint weigh_axis(input longint wx, input longint wy, input longint off,
                                          input longint x, input longint y);
        longint divisor;
        longint quo;
        divisor = scale_q;
        if (divisor == 0)
            divisor = 1;
        quo = (wx * x + wy * y + off) / divisor;
        if (quo > SAT_HI)
            quo = SAT_HI;
        else if (quo < SAT_LO)
            quo = SAT_LO;
        return quo;
    endfunction

    function automatic logic signed [31:0] apply_deadband(input longint fresh,
                                                          input logic signed [31:0] held);
        longint      span;
        logic [31:0] snapped;
        span = fresh - held;
        if (span < 0)
            span = -span;
        if (span < DEADBAND)
            return held;
        snapped = fresh[31:0];
        snapped[1:0] = 2'b00;
        return snapped;
    endfunction

    function automatic screen_pt_t calibrate_point(input logic [15:0] pen,
                                                   input logic signed [15:0] x,
                                                   input logic signed [15:0] y);
        screen_pt_t pt;
        if (cal_on)
        begin
            held_x = apply_deadband(weigh_axis(ka, kb, kc, x, y), held_x);
            held_y = apply_deadband(weigh_axis(kd, ke, kf, x, y), held_y);
            pt.sx = held_x >>> 2;
            pt.sy = held_y >>> 2;
        end
        else
        begin
            pt.sx = x;
            pt.sy = y;
        end
        pt.pen = (pen != 16'h0000);
        return pt;
    endfunction

    function automatic logic [31:0] pick_coef(input int mode);
        logic [31:0] v;
        case (mode)
            1: begin v = $urandom_range(0, 131071); return v - 32'd65536; end
            3:
            begin
                case ($urandom_range(0, 4))
                    0: return 32'h80000000;
                    1: return 32'h7fffffff;
                    2: return 32'h00000000;
                    3: return 32'h00000001;
                    default: return 32'hffffffff;
                endcase
            end
            4: begin v = $urandom_range(0, 32); return v - 32'd16; end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_scale(input int mode);
        logic [31:0] v;
        case (mode)
            1:
            begin
                v = $urandom_range(1, 65536);
                v[31] = 1'($urandom_range(0, 1));
                return v;
            end
            3:
            begin
                case ($urandom_range(0, 4))
                    0: return 32'h00000000;
                    1: return 32'h00000001;
                    2: return 32'h7fffffff;
                    3: return 32'h80000000;
                    default: return 32'hffffffff;
                endcase
            end
            4: return $urandom_range(0, 8);
            default: return $urandom;
        endcase
    endfunction

    task automatic write_reg(input tach_pkg::cfg_index_t idx, input logic [31:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        load_register(idx, value);
    endtask

    // Drop the sample valid and wait until every pending result has drained
    task automatic settle_unit();
        sample_ch.valid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_sample(input logic [15:0] pen, input logic [15:0] x,
                               input logic [15:0] y, input bit fixed,
                               input screen_pt_t fixed_pt);
        int         gap;
        screen_pt_t pt;
        gap = fast_send ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid    <= 1'b1;
        sample_ch.pen_word <= pen;
        sample_ch.raw_x    <= x;
        sample_ch.raw_y    <= y;
        do @(posedge clk); while (!sample_ch.ready);
        pt = calibrate_point(pen, x, y);
        pending_points.push_back(fixed ? fixed_pt : pt);
    endtask

    // Result side: random stalls, one long hold on request, field-by-field compare
    initial
    begin
        int         stall;
        screen_pt_t want;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_output)
            begin
                hold_output = 1'b0;
                stall = LONG_HOLD;
            end
            else
                stall = fast_take ? 0 : $urandom_range(0, 19);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
            if (pending_points.size() == 0)
            begin
                $error("unexpected result transaction: screen_x=%0d screen_y=%0d pen_down=%0d",
                       result_ch.screen_x, result_ch.screen_y, result_ch.pen_down);
                errors++;
            end
            else
            begin
                want = pending_points.pop_front();
                if (result_ch.screen_x !== want.sx)
                begin
                    $error("screen_x: expected %0d, got %0d", want.sx, result_ch.screen_x);
                    errors++;
                end
                if (result_ch.screen_y !== want.sy)
                begin
                    $error("screen_y: expected %0d, got %0d", want.sy, result_ch.screen_y);
                    errors++;
                end
                if (result_ch.pen_down !== want.pen)
                begin
                    $error("pen_down: expected %0d, got %0d", want.pen, result_ch.pen_down);
                    errors++;
                end
            end
        end
    end

    // Watchdog: cycles without any transaction on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        int          sent;
        int          phase_no;
        int          mode;
        int          n_items;
        int          r;
        bit          in_cfg;
        logic [15:0] px, py, pen;
        logic [31:0] en_word;
        screen_pt_t  fixed_pt;

        errors      = 0;
        idle_cycles = 0;
        fast_send   = 1'b0;
        fast_take   = 1'b0;
        hold_output = 1'b0;
        cal_on      = 1'b0;
        ka = 1; kb = 0; kc = 0; kd = 0; ke = 1; kf = 0;
        scale_q     = 1;
        held_x      = 0;
        held_y      = 0;

        rst_n              = 1'b0;
        sample_ch.valid    = 1'b0;
        sample_ch.pen_word = '0;
        sample_ch.raw_x    = '0;
        sample_ch.raw_y    = '0;
        result_ch.ready    = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = tach_pkg::CFG_ENABLE;
        cfg_ch.data        = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        in_cfg = 1'b0;
        foreach (steps[i])
        begin
            if (steps[i].kind == STEP_WRITE)
            begin
                if (!in_cfg)
                    settle_unit();
                write_reg(steps[i].idx, steps[i].data);
                in_cfg = 1'b1;
            end
            else
            begin
                if (in_cfg)
                    cfg_ch.valid <= 1'b0;
                in_cfg = 1'b0;
                fixed_pt = '{steps[i].ex, steps[i].ey, steps[i].ep};
                send_sample(steps[i].pen, steps[i].x, steps[i].y,
                            steps[i].kind == STEP_CHECKED, fixed_pt);
            end
        end

        sent     = 0;
        phase_no = 0;
        px       = '0;
        py       = '0;
        while (sent < RANDOM_ITEMS)
        begin
            // mode 0 raw, 1 realistic calibration, 2 random words, 3 extremes, 4 small gains
            mode = (phase_no < 5) ? phase_no : $urandom_range(0, 4);
            settle_unit();
            en_word    = $urandom;
            en_word[0] = (mode != 0);
            write_reg(tach_pkg::CFG_ENABLE, en_word);
            write_reg(tach_pkg::CFG_COEF_A, pick_coef(mode));
            write_reg(tach_pkg::CFG_COEF_B, pick_coef(mode));
            write_reg(tach_pkg::CFG_COEF_C, pick_coef(mode == 4 ? 2 : mode));
            write_reg(tach_pkg::CFG_COEF_D, pick_coef(mode));
            write_reg(tach_pkg::CFG_COEF_E, pick_coef(mode));
            write_reg(tach_pkg::CFG_COEF_F, pick_coef(mode == 4 ? 2 : mode));
            write_reg(tach_pkg::CFG_SCALE, pick_scale(mode));
            cfg_ch.valid <= 1'b0;

            fast_send = ($urandom_range(0, 3) == 0);
            fast_take = ($urandom_range(0, 3) == 0);
            if (phase_no == 1)
            begin
                fast_send   = 1'b1;
                hold_output = 1'b1;
            end

            n_items = $urandom_range(20, 60);
            for (int k = 0; k < n_items; k++)
            begin
                r = $urandom_range(0, 9);
                if (r < 7)
                begin
                    // pen drag: small moves around the last point
                    px = px + 16'($urandom_range(0, 16)) - 16'd8;
                    py = py + 16'($urandom_range(0, 16)) - 16'd8;
                end
                else if (r == 7)
                begin
                    px = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
                    py = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
                end
                else
                begin
                    px = 16'($urandom);
                    py = 16'($urandom);
                end
                case ($urandom_range(0, 4))
                    0, 1: pen = 16'h0000;
                    2:    pen = 16'h0001 << $urandom_range(0, 15);
                    default: pen = 16'($urandom);
                endcase
                send_sample(pen, px, py, 1'b0, '0);
                sent++;
            end
            phase_no++;
        end

        settle_unit();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
